[rtl/core/cdsd_pkg.sv]
// Shared types, constants and calendar arithmetic for the civil date / serial day converter.
package cdsd_pkg;

    // Valid window: 1900-01-01 is serial 2, 9999-12-31 is serial 2958465
    localparam logic [13:0] YEAR_MIN   = 14'd1900;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [21:0] SERIAL_MIN = 22'd2;
    localparam logic [21:0] SERIAL_MAX = 22'd2958465;

    // Day count from 0000-03-01 to serial zero, less the March-based year offset of Jan 1
    localparam logic [21:0] JAN1_BIAS = 22'd693593;

    // Year estimate: (serial - EST_BIAS) / 365.2425, biased about half a year low
    localparam logic [21:0] EST_BIAS  = 22'd185;
    localparam logic [15:0] EST_RECIP = 16'd45934;   // 2^24 / 365.2425

    // Reciprocal for x / 100 on 14-bit values, exact for every 14-bit x
    localparam logic [12:0] DIV100_RECIP = 13'd5243; // 2^19 / 100, rounded up

    // Operation codes
    localparam logic OP_PACK   = 1'b0;
    localparam logic OP_UNPACK = 1'b1;

    typedef struct packed {
        logic        op;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [21:0] serial;
    } in_item_t;

    // After the first step: packed serial or echoed serial, plus year estimate
    typedef struct packed {
        logic        op;
        logic        ok;
        logic [21:0] serial;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [12:0] est;
    } s1_t;

    // After the second step: resolved year and day of year
    typedef struct packed {
        logic        op;
        logic        ok;
        logic [21:0] serial;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [8:0]  doy;
    } s2_t;

    typedef struct packed {
        logic [21:0] serial;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        ok;
    } out_item_t;

    // x / 100 by reciprocal multiply
    function automatic logic [7:0] div100(input logic [13:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'(DIV100_RECIP);
        return p[26:19];
    endfunction

    function automatic logic [6:0] rem100(input logic [13:0] x);
        logic [13:0] r;
        r = x - 14'(div100(x)) * 14'd100;
        return r[6:0];
    endfunction

    // Divisible by 4 and either not by 100 or by 400 (400 | y  <=>  4 | y and 100 | y/4)
    function automatic logic is_leap(input logic [13:0] y);
        logic [6:0] r_y;
        logic [6:0] r_q;
        r_y = rem100(y);
        r_q = rem100({2'b00, y[13:2]});
        return (y[1:0] == 2'b00) && ((r_y != 7'd0) || (r_q == 7'd0));
    endfunction

    // Serial of January 1 of year y (y >= 1900)
    function automatic logic [21:0] jan1_serial(input logic [13:0] y);
        logic [13:0] ya;
        logic [21:0] acc;
        ya  = y - 14'd1;
        acc = 22'(ya) * 22'd365 + 22'(ya[13:2]) - 22'(div100(ya))
            + 22'(div100({2'b00, ya[13:2]}));
        return acc - JAN1_BIAS;
    endfunction

    // Days in the year before the first of month m
    function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (m >= 4'd3) && (m <= 4'd12))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

    // Length of month m, zero for a month code that does not exist
    function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

[rtl/core/cdsd_pack.sv]
// Date to serial: validity check and serial day number for a year, month and day.
module cdsd_pack (
    input  cdsd_pkg::in_item_t item,
    output logic               ok,
    output logic [21:0]        serial
);
    import cdsd_pkg::*;

    logic       leap;
    logic [4:0] mlen;

    // Month length also rejects month codes outside 1..12
    always_comb
    begin
        leap   = is_leap(item.year);
        mlen   = month_length(item.month, leap);
        ok     = (item.year >= YEAR_MIN) && (item.year <= YEAR_MAX)
              && (item.day != 5'd0) && (item.day <= mlen);
        serial = ok ? (jan1_serial(item.year) + 22'(days_before_month(item.month, leap))
                       + 22'(item.day) - 22'd1)
                    : '0;
    end

endmodule

[rtl/core/cdsd_year_est.sv]
// Serial to date, first step: range check and a year estimate by reciprocal multiply.
module cdsd_year_est (
    input  logic [21:0] serial,
    output logic        ok,
    output logic [12:0] est
);
    import cdsd_pkg::*;

    logic [21:0] span;
    logic [37:0] prod;

    // Estimate is the true year offset from 1900 or one below it
    always_comb
    begin
        ok   = (serial >= SERIAL_MIN) && (serial <= SERIAL_MAX);
        span = (serial >= EST_BIAS) ? (serial - EST_BIAS) : '0;
        prod = 38'(span) * 38'(EST_RECIP);
        est  = prod[36:24];
    end

endmodule

[rtl/core/cdsd_year_sel.sv]
// Serial to date, second step: pick the year from two candidates and form the day of year.
module cdsd_year_sel (
    input  cdsd_pkg::s1_t cur,
    output cdsd_pkg::s2_t nxt
);
    import cdsd_pkg::*;

    logic [13:0] y_lo;
    logic [13:0] y_hi;
    logic [21:0] j_lo;
    logic [21:0] j_hi;
    logic        take_hi;
    logic [21:0] diff;

    always_comb
    begin
        y_lo    = YEAR_MIN + 14'(cur.est);
        y_hi    = y_lo + 14'd1;
        j_lo    = jan1_serial(y_lo);
        j_hi    = jan1_serial(y_hi);
        take_hi = (cur.serial >= j_hi);
        diff    = take_hi ? (cur.serial - j_hi) : (cur.serial - j_lo);

        nxt.op     = cur.op;
        nxt.ok     = cur.ok;
        nxt.serial = cur.serial;
        nxt.month  = cur.month;
        nxt.day    = cur.day;
        nxt.doy    = diff[8:0];
        nxt.year   = (cur.op == OP_UNPACK) ? (take_hi ? y_hi : y_lo) : cur.year;
    end

endmodule

[rtl/core/cdsd_month_split.sv]
// Serial to date, last step: month and day from day of year; final result fields.
module cdsd_month_split (
    input  cdsd_pkg::s2_t       cur,
    output cdsd_pkg::out_item_t res
);
    import cdsd_pkg::*;

    logic       leap;
    logic [3:0] mon;
    logic [8:0] day_full;

    // Eleven independent compares against the month start table
    always_comb
    begin
        leap = is_leap(cur.year);
        mon  = 4'd1;
        for (int i = 2; i <= 12; i++)
        begin
            if (cur.doy >= days_before_month(4'(i), leap))
            begin
                mon = 4'(i);
            end
        end
        day_full = cur.doy - days_before_month(mon, leap) + 9'd1;
    end

    // Pack echoes its inputs; unpack zeroes the date of a serial out of range
    always_comb
    begin
        res.serial = cur.serial;
        res.ok     = cur.ok;
        if (cur.op == OP_PACK)
        begin
            res.year  = cur.year;
            res.month = cur.month;
            res.day   = cur.day;
        end
        else if (cur.ok)
        begin
            res.year  = cur.year;
            res.month = mon;
            res.day   = day_full[4:0];
        end
        else
        begin
            res.year  = '0;
            res.month = '0;
            res.day   = '0;
        end
    end

endmodule

[rtl/core/civil_date_serial_day_converter_core.sv]
// A result shows on the output register after the input, estimate and year stages.
// Throughput: one item per cycle when not stalled; four registered stages (input, estimate,
// year, result), and ready propagates back so any free stage lets the next item in.
// Reset: rst_n clears every stage's valid bit at once; payload registers are not reset.
// The block holds no other state.
module civil_date_serial_day_converter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [13:0] in_year,
    input  logic [3:0]  in_month,
    input  logic [4:0]  in_day,
    input  logic [21:0] in_serial,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [21:0] out_serial,
    output logic [13:0] out_year,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic        valid_res
);
    import cdsd_pkg::*;

    in_item_t  in_reg;
    s1_t       s1_reg;
    s2_t       s2_reg;
    out_item_t out_reg;

    in_item_t  in_next;
    s1_t       s1_next;
    s2_t       s2_next;
    out_item_t out_next;

    logic in_v_reg, s1_v_reg, s2_v_reg, out_v_reg;
    logic in_v_next, s1_v_next, s2_v_next, out_v_next;

    logic accept;
    logic free_out, free_s2, free_s1, free_in;
    logic mv_in, mv_s1, mv_s2;

    logic        pack_ok;
    logic [21:0] pack_serial;
    logic        est_ok;
    logic [12:0] est;

    // Stall chain: a stage is free when empty or when it moves on this cycle
    always_comb
    begin
        free_out = !out_v_reg || out_ready;
        mv_s2    = s2_v_reg && free_out;
        free_s2  = !s2_v_reg || free_out;
        mv_s1    = s1_v_reg && free_s2;
        free_s1  = !s1_v_reg || free_s2;
        mv_in    = in_v_reg && free_s1;
        free_in  = !in_v_reg || free_s1;
        accept   = in_valid && free_in;

        in_v_next  = accept ? 1'b1 : (mv_in ? 1'b0 : in_v_reg);
        s1_v_next  = mv_in  ? 1'b1 : (mv_s1 ? 1'b0 : s1_v_reg);
        s2_v_next  = mv_s1  ? 1'b1 : (mv_s2 ? 1'b0 : s2_v_reg);
        out_v_next = mv_s2  ? 1'b1 : ((out_v_reg && out_ready) ? 1'b0 : out_v_reg);
    end

    // Input item capture
    always_comb
    begin
        in_next.op     = op;
        in_next.year   = in_year;
        in_next.month  = in_month;
        in_next.day    = in_day;
        in_next.serial = in_serial;
    end

    // First step: pack, and year estimate for unpack
    cdsd_pack u_pack (
        .item   (in_reg),
        .ok     (pack_ok),
        .serial (pack_serial)
    );

    cdsd_year_est u_year_est (
        .serial (in_reg.serial),
        .ok     (est_ok),
        .est    (est)
    );

    always_comb
    begin
        s1_next.op     = in_reg.op;
        s1_next.ok     = (in_reg.op == OP_UNPACK) ? est_ok : pack_ok;
        s1_next.serial = (in_reg.op == OP_UNPACK) ? in_reg.serial : pack_serial;
        s1_next.year   = in_reg.year;
        s1_next.month  = in_reg.month;
        s1_next.day    = in_reg.day;
        s1_next.est    = est;
    end

    // Second step: year resolve
    cdsd_year_sel u_year_sel (
        .cur (s1_reg),
        .nxt (s2_next)
    );

    // Third step: month and day
    cdsd_month_split u_month_split (
        .cur (s2_reg),
        .res (out_next)
    );

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // Payload registers load when their upstream stage moves
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= in_next;
        end
        if (mv_in)
        begin
            s1_reg <= s1_next;
        end
        if (mv_s1)
        begin
            s2_reg <= s2_next;
        end
        if (mv_s2)
        begin
            out_reg <= out_next;
        end
    end

    assign in_ready   = free_in;
    assign out_valid  = out_v_reg;
    assign out_serial = out_reg.serial;
    assign out_year   = out_reg.year;
    assign out_month  = out_reg.month;
    assign out_day    = out_reg.day;
    assign valid_res  = out_reg.ok;

endmodule

[rtl/core/cdsd_checker.sv]
// Port-level checker for the converter core, bound to the top level.
module cdsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        op,
    input logic [13:0] in_year,
    input logic [3:0]  in_month,
    input logic [4:0]  in_day,
    input logic [21:0] in_serial,
    input logic        out_valid,
    input logic        out_ready,
    input logic [21:0] out_serial,
    input logic [13:0] out_year,
    input logic [3:0]  out_month,
    input logic [4:0]  out_day,
    input logic        valid_res
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_serial) && $stable(out_year)
            && $stable(out_month) && $stable(out_day) && $stable(valid_res))
        else $error("stalled result changed");

    // A valid result carries a year in the supported window
    a_year_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> (out_year >= 14'd1900) && (out_year <= 14'd9999))
        else $error("valid result with year outside 1900..9999");

    // A valid result carries a real month and day
    a_month_day: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> (out_month >= 4'd1) && (out_month <= 4'd12)
            && (out_day >= 5'd1) && (out_day <= 5'd31))
        else $error("valid result with impossible month or day");

    // An invalid item with a nonzero serial is an unpack out of range: date is zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res && (out_serial != 22'd0) |->
            (out_year == 14'd0) && (out_month == 4'd0) && (out_day == 5'd0))
        else $error("out of range serial gave a nonzero date");

endmodule

bind civil_date_serial_day_converter_core cdsd_checker u_cdsd_checker (.*);

[sim/civil_date_serial_day_converter_core_tb.sv]
// Self-checking testbench for the civil date / serial day converter core.
module civil_date_serial_day_converter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdsd_pkg::*;

    // Calendar arithmetic constants (day counts since 0000-03-01) and run limits
    localparam int unsigned DAYS_400Y      = 146097;
    localparam int unsigned MARCH0_OFFSET  = 693899;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned SETTLE_CYCLES  = 8;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_STARVED} rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = 1'b0;
    logic [13:0] in_year = '0;
    logic [3:0]  in_month = '0;
    logic [4:0]  in_day = '0;
    logic [21:0] in_serial = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [21:0] out_serial;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic        valid_res;

    out_item_t   pending_dates[$];
    out_item_t   oldest_date;
    int          error_count = 0;
    int          pack_count = 0;
    int          unpack_count = 0;
    int          valid_seen = 0;
    int          invalid_seen = 0;
    int          burst_left = 0;
    bit          sender_gaps = 1'b1;

    civil_date_serial_day_converter_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .in_year    (in_year),
        .in_month   (in_month),
        .in_day     (in_day),
        .in_serial  (in_serial),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_serial (out_serial),
        .out_year   (out_year),
        .out_month  (out_month),
        .out_day    (out_day),
        .valid_res  (valid_res)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Gregorian leap rule
    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Expected result of one conversion item
    function automatic out_item_t convert_civil(input logic op_i, input logic [13:0] y,
                                                input logic [3:0] m, input logic [4:0] d,
                                                input logic [21:0] s);
        out_item_t   r;
        int unsigned ya, era, yoe, mi, doy, doe, z, mp, dd, mm, yy;
        r = '0;
        if (op_i == OP_PACK)
        begin
            r.year  = y;
            r.month = m;
            r.day   = d;
            if (y >= YEAR_MIN && y <= YEAR_MAX && m >= 1 && m <= 12 && d >= 1
                && d <= days_in_month(y, m))
            begin
                // March-based year, so the leap day falls at the end
                ya  = (m <= 2) ? int'(y) - 1 : int'(y);
                era = ya / 400;
                yoe = ya - era * 400;
                mi  = (m > 2) ? int'(m) - 3 : int'(m) + 9;
                doy = (153 * mi + 2) / 5 + d - 1;
                doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
                r.serial = 22'(era * DAYS_400Y + doe - MARCH0_OFFSET);
                r.ok     = 1'b1;
            end
        end
        else
        begin
            r.serial = s;
            if (s >= SERIAL_MIN && s <= SERIAL_MAX)
            begin
                z   = s + MARCH0_OFFSET;
                era = z / DAYS_400Y;
                doe = z - era * DAYS_400Y;
                yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
                doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
                mp  = (5 * doy + 2) / 153;
                dd  = doy - (153 * mp + 2) / 5 + 1;
                mm  = (mp < 10) ? mp + 3 : mp - 9;
                yy  = yoe + era * 400 + ((mm <= 2) ? 1 : 0);
                r.year  = 14'(yy);
                r.month = 4'(mm);
                r.day   = 5'(dd);
                r.ok    = 1'b1;
            end
        end
        return r;
    endfunction

    // Drive one item at the falling edge, hold it until accepted
    task automatic send_item(input logic op_i, input logic [13:0] y, input logic [3:0] m,
                             input logic [4:0] d, input logic [21:0] s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (sender_gaps)
            begin
                gap = $urandom_range(1, 6);
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid  = 1'b1;
        op        = op_i;
        in_year   = y;
        in_month  = m;
        in_day    = d;
        in_serial = s;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        pending_dates.push_back(convert_civil(op_i, y, m, d, s));
        burst_left--;
        if (op_i == OP_PACK)
        begin
            pack_count++;
        end
        else
        begin
            unpack_count++;
        end
    endtask

    // Hold off the sender until every pending result has come back
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid   = 1'b0;
        burst_left = 0;
        while (pending_dates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_pack(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d);
        send_item(OP_PACK, y, m, d, 22'($urandom));
    endtask

    task automatic send_unpack(input logic [21:0] s);
        send_item(OP_UNPACK, 14'($urandom), 4'($urandom), 5'($urandom), s);
    endtask

    // Date-to-serial corner cases: range ends, leap rules, nonexistent dates
    task automatic test_pack_edges();
        send_pack(14'd1900, 4'd1, 5'd1);
        send_pack(14'd9999, 4'd12, 5'd31);
        send_pack(14'd1970, 4'd1, 5'd1);
        send_pack(14'd2000, 4'd2, 5'd29);
        send_pack(14'd1900, 4'd2, 5'd29);
        send_pack(14'd2024, 4'd2, 5'd29);
        send_pack(14'd2023, 4'd2, 5'd29);
        send_pack(14'd2022, 4'd2, 5'd31);
        send_pack(14'd1899, 4'd12, 5'd31);
        send_pack(14'd10000, 4'd1, 5'd1);
        send_pack(14'h3FFF, 4'hF, 5'h1F);
        send_pack(14'd2021, 4'd0, 5'd10);
        send_pack(14'd2021, 4'd13, 5'd10);
        send_pack(14'd2021, 4'd6, 5'd0);
        send_pack(14'd2021, 4'd4, 5'd31);
        send_pack(14'd0, 4'd0, 5'd0);
    endtask

    // Serial-to-date corner cases around the valid window
    task automatic test_unpack_edges();
        send_unpack(22'd0);
        send_unpack(22'd1);
        send_unpack(SERIAL_MIN);
        send_unpack(22'd61);
        send_unpack(22'd25569);
        send_unpack(SERIAL_MAX);
        send_unpack(22'd2958466);
        send_unpack(22'h3FFFFF);
    endtask

    // Mostly well-formed dates and in-range serials, the rest noise
    task automatic test_random_mix(input int n);
        int          sel;
        int unsigned y, m, d, len;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            case ($urandom_range(0, 5))
                0:       y = 1900 + $urandom_range(0, 3);
                1:       y = 9999 - $urandom_range(0, 3);
                2:       y = $urandom_range(19, 99) * 100;
                default: y = $urandom_range(1900, 9999);
            endcase
            m   = $urandom_range(1, 12);
            len = days_in_month(y, m);
            case ($urandom_range(0, 3))
                0:       d = len;
                1:       d = 1;
                default: d = $urandom_range(1, len);
            endcase
            if (sel < 40)
            begin
                send_pack(14'(y), 4'(m), 5'(d));
            end
            else if (sel < 55)
            begin
                // Near misses and raw noise
                case ($urandom_range(0, 3))
                    0:       send_pack(14'(y), 4'(m), 5'(len + 1));
                    1:       send_pack(($urandom_range(0, 1) != 0) ? 14'd1899 : 14'd10000,
                                       4'(m), 5'(d));
                    2:       send_pack(14'(y), 4'($urandom_range(13, 15)), 5'(d));
                    default: send_pack(14'($urandom), 4'($urandom), 5'($urandom));
                endcase
            end
            else if (sel < 85)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_unpack(($urandom_range(0, 1) != 0)
                                ? 22'(SERIAL_MIN + $urandom_range(0, 400))
                                : 22'(SERIAL_MAX - $urandom_range(0, 400)));
                end
                else
                begin
                    send_unpack(22'($urandom_range(SERIAL_MIN, SERIAL_MAX)));
                end
            end
            else
            begin
                send_unpack(22'($urandom_range(0, 22'h3FFFFF)));
            end
        end
    endtask

    // Back-to-back items with the sender never idling
    task automatic test_steady_stream(input int n);
        sender_gaps = 1'b0;
        test_random_mix(n);
        sender_gaps = 1'b1;
    endtask

    // Receiver backpressure: modes change at random intervals
    initial
    begin
        rx_mode_t rx_mode;
        int       rx_left;
        int       rx_phase;
        rx_mode  = RX_OPEN;
        rx_left  = 0;
        rx_phase = 0;
        forever
        begin
            @(negedge clk);
            if (rx_left == 0)
            begin
                rx_mode  = rx_mode_t'($urandom_range(0, 3));
                rx_left  = $urandom_range(20, 120);
                rx_phase = 0;
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:     out_ready = 1'b1;
                RX_RANDOM:   out_ready = ($urandom_range(0, 3) != 0);
                RX_PERIODIC:
                begin
                    out_ready = (rx_phase % 5) < 3;
                    rx_phase++;
                end
                default:     out_ready = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Compare each accepted result with the oldest pending expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dates.size() == 0)
            begin
                $error("result item with no expectation pending: serial %0d", out_serial);
                error_count++;
            end
            else
            begin
                oldest_date = pending_dates.pop_front();
                if (out_serial !== oldest_date.serial)
                begin
                    $error("out_serial: expected %0d, got %0d", oldest_date.serial, out_serial);
                    error_count++;
                end
                if (out_year !== oldest_date.year)
                begin
                    $error("out_year: expected %0d, got %0d", oldest_date.year, out_year);
                    error_count++;
                end
                if (out_month !== oldest_date.month)
                begin
                    $error("out_month: expected %0d, got %0d", oldest_date.month, out_month);
                    error_count++;
                end
                if (out_day !== oldest_date.day)
                begin
                    $error("out_day: expected %0d, got %0d", oldest_date.day, out_day);
                    error_count++;
                end
                if (valid_res !== oldest_date.ok)
                begin
                    $error("valid_res: expected %0d, got %0d", oldest_date.ok, valid_res);
                    error_count++;
                end
                if (oldest_date.ok)
                begin
                    valid_seen++;
                end
                else
                begin
                    invalid_seen++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("civil_date_serial_day_converter_core_tb: done, errors");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_pack_edges();
        test_unpack_edges();
        wait_for_drain();
        test_random_mix(220);
        wait_for_drain();
        test_steady_stream(60);
        test_random_mix(220);
        wait_for_drain();

        $display("Converted %0d dates to serials and %0d serials to dates.",
                 pack_count, unpack_count);
        $display("Results checked: %0d valid, %0d rejected, under varying backpressure.",
                 valid_seen, invalid_seen);
        if (error_count == 0 && pending_dates.size() == 0)
        begin
            $display("civil_date_serial_day_converter_core_tb: done, clean");
        end
        else
        begin
            $display("civil_date_serial_day_converter_core_tb: done, errors");
        end
        $finish;
    end

endmodule
